@@ src/swev_pkg.sv @@
// shared types, constants and microcode rom of the sliding window extrema vote block
package swev_pkg;

    localparam int MAX_WINDOW_DEF = 63;
    localparam int SAMPLE_W       = 16;
    localparam int VOTE_W         = 7;
    localparam int WLEN_W         = 6;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int PC_W           = 4;

    localparam logic [WLEN_W-1:0]        WLEN_RESET = WLEN_W'(16);
    localparam logic signed [VOTE_W-1:0] VOTE_MAX   = VOTE_W'(63);
    localparam logic signed [VOTE_W-1:0] VOTE_MIN   = -VOTE_W'(63);

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [PC_W-1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_RD_LO,
        ST_WR_LO,
        ST_RD_HI,
        ST_WR_HI,
        ST_RD_HEAD,
        ST_EMIT_POP,
        ST_PUSH,
        ST_FLUSH_RD,
        ST_FLUSH_EMIT,
        ST_FLUSH_TEST,
        ST_BACK
    } step_t;

    typedef enum logic [1:0] {
        VSRC_NONE,
        VSRC_LO,
        VSRC_HI,
        VSRC_HEAD
    } vote_src_t;

    typedef enum logic [1:0] {
        VUPD_NONE,
        VUPD_DEC_LO,
        VUPD_INC_HI
    } vote_upd_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_POP,
        EMIT_FLUSH
    } emit_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SHORT,
        COND_SCAN_MORE,
        COND_OUT_BUSY,
        COND_NOT_EOS,
        COND_HELD_NZ
    } cond_t;

    typedef struct packed {
        logic      in_take;
        logic      scan_clr;
        logic      scan_step;
        vote_src_t vote_src;
        vote_upd_t vote_upd;
        emit_t     emit;
        logic      push;
        cond_t     cond;
        step_t     target;
    } ctl_word_t;

    typedef struct packed {
        logic in_wait;
        logic short_win;
        logic scan_more;
        logic out_busy;
        logic not_eos;
        logic held_nz;
    } status_t;

    function automatic ctl_word_t ucode_rom(step_t pc);
        ctl_word_t w;
        w = '{in_take: 1'b0, scan_clr: 1'b0, scan_step: 1'b0, vote_src: VSRC_NONE,
              vote_upd: VUPD_NONE, emit: EMIT_NONE, push: 1'b0, cond: COND_ALWAYS,
              target: ST_IDLE};
        case (pc)
            ST_IDLE:
            begin
                w.in_take = 1'b1;
                w.cond    = COND_NO_INPUT;
                w.target  = ST_IDLE;
            end
            ST_CHECK:
            begin
                w.scan_clr = 1'b1;
                w.cond     = COND_SHORT;
                w.target   = ST_PUSH;
            end
            ST_SCAN:
            begin
                w.scan_step = 1'b1;
                w.cond      = COND_SCAN_MORE;
                w.target    = ST_SCAN;
            end
            ST_RD_LO:
            begin
                w.vote_src = VSRC_LO;
                w.target   = ST_WR_LO;
            end
            ST_WR_LO:
            begin
                w.vote_upd = VUPD_DEC_LO;
                w.target   = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                w.vote_src = VSRC_HI;
                w.target   = ST_WR_HI;
            end
            ST_WR_HI:
            begin
                w.vote_upd = VUPD_INC_HI;
                w.target   = ST_RD_HEAD;
            end
            ST_RD_HEAD:
            begin
                w.vote_src = VSRC_HEAD;
                w.target   = ST_EMIT_POP;
            end
            ST_EMIT_POP:
            begin
                w.emit   = EMIT_POP;
                w.cond   = COND_OUT_BUSY;
                w.target = ST_EMIT_POP;
            end
            ST_PUSH:
            begin
                w.push   = 1'b1;
                w.cond   = COND_NOT_EOS;
                w.target = ST_IDLE;
            end
            ST_FLUSH_RD:
            begin
                w.vote_src = VSRC_HEAD;
                w.target   = ST_FLUSH_EMIT;
            end
            ST_FLUSH_EMIT:
            begin
                w.emit   = EMIT_FLUSH;
                w.cond   = COND_OUT_BUSY;
                w.target = ST_FLUSH_EMIT;
            end
            ST_FLUSH_TEST:
            begin
                w.cond   = COND_HELD_NZ;
                w.target = ST_FLUSH_RD;
            end
            ST_BACK:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ src/swev_if.sv @@
// request channel interfaces for samples in and votes out
interface swev_in_if import swev_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_sequence;

    modport source (output valid, output sample, output end_of_sequence, input ready);
    modport sink (input valid, input sample, input end_of_sequence, output ready);
endinterface

interface swev_out_if import swev_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [VOTE_W-1:0] vote;
    logic                     last_vote;

    modport source (output valid, output vote, output last_vote, input ready);
    modport sink (input valid, input vote, input last_vote, output ready);
endinterface

@@ src/swev_apb.sv @@
// apb register port holding the window length
module swev_apb import swev_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [WLEN_W-1:0]     window_length
);

    logic [WLEN_W-1:0] wlen_reg;
    logic [WLEN_W-1:0] wlen_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);

    always_comb
    begin
        wlen_next = wlen_reg;
        if (wr_en)
        begin
            wlen_next = pwdata[WLEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_RESET;
        end
        else
        begin
            wlen_reg <= wlen_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW_LENGTH)
        begin
            prdata = {{(APB_DATA_W-WLEN_W){1'b0}}, wlen_reg};
        end
    end

    assign window_length = wlen_reg;

endmodule

@@ src/swev_useq.sv @@
// microcode sequencer: step counter, control rom and conditional jumps
module swev_useq import swev_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  status_t   status,
    output ctl_word_t ctl
);

    step_t pc_reg;
    step_t pc_next;
    logic  take_jump;

    always_comb
    begin
        ctl = ucode_rom(pc_reg);
    end

    always_comb
    begin
        case (ctl.cond)
            COND_ALWAYS:    take_jump = 1'b1;
            COND_NO_INPUT:  take_jump = status.in_wait;
            COND_SHORT:     take_jump = status.short_win;
            COND_SCAN_MORE: take_jump = status.scan_more;
            COND_OUT_BUSY:  take_jump = status.out_busy;
            COND_NOT_EOS:   take_jump = status.not_eos;
            COND_HELD_NZ:   take_jump = status.held_nz;
            default:        take_jump = 1'b1;
        endcase
        if (take_jump)
        begin
            pc_next = ctl.target;
        end
        else
        begin
            pc_next = step_t'(PC_W'(pc_reg + PC_W'(1)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ src/swev_datapath.sv @@
// sample and vote memories, window scan, vote update and output register
module swev_datapath import swev_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_word_t         ctl,
    input  logic [WLEN_W-1:0] window_length,
    output status_t           status,
    swev_in_if.sink           sample_ch,
    swev_out_if.source        vote_ch
);

    localparam int PTR_W = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH = 1 << PTR_W;
    localparam logic [PTR_W-1:0] MAX_W = PTR_W'(MAX_WINDOW);
    localparam logic [PTR_W-1:0] ONE   = PTR_W'(1);

    logic signed [SAMPLE_W-1:0] smp_mem [DEPTH];
    logic signed [VOTE_W-1:0]   vote_mem [DEPTH];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] held_reg, held_next;
    logic [PTR_W-1:0] k_reg, k_next;
    logic [PTR_W-1:0] lo_reg, lo_next;
    logic [PTR_W-1:0] hi_reg, hi_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SAMPLE_W-1:0] smp_rd_reg;
    logic signed [VOTE_W-1:0]   vote_rd_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       eos_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [VOTE_W-1:0]   out_vote_reg;
    logic                       out_last_reg;

    logic [PTR_W-1:0]         w_eff;
    logic [PTR_W-1:0]         smp_rd_addr;
    logic                     smp_rd_en;
    logic [PTR_W-1:0]         vote_rd_addr;
    logic [PTR_W-1:0]         vote_wr_addr;
    logic signed [VOTE_W-1:0] vote_wr_data;
    logic                     vote_wr_en;
    logic [PTR_W-1:0]         tail_addr;
    logic                     in_fire;
    logic                     out_free;
    logic                     emit_fire;

    // effective window: zero acts as one, saturate at the maximum
    always_comb
    begin
        if (window_length == '0)
        begin
            w_eff = ONE;
        end
        else if (int'(window_length) > MAX_WINDOW)
        begin
            w_eff = MAX_W;
        end
        else
        begin
            w_eff = PTR_W'(window_length);
        end
    end

    assign sample_ch.ready = ctl.in_take;
    assign in_fire         = sample_ch.valid && ctl.in_take;
    assign out_free        = !out_valid_reg || vote_ch.ready;
    assign emit_fire       = (ctl.emit != EMIT_NONE) && out_free;
    assign tail_addr       = PTR_W'(head_reg + held_reg);

    assign status.in_wait   = !sample_ch.valid;
    assign status.short_win = held_reg < w_eff;
    assign status.scan_more = k_reg != PTR_W'(w_eff - ONE);
    assign status.out_busy  = !out_free;
    assign status.not_eos   = !eos_reg;
    assign status.held_nz   = held_reg != '0;

    // sample read stream for the scan, one entry per cycle
    assign smp_rd_en   = ctl.scan_clr || ctl.scan_step;
    assign smp_rd_addr = ctl.scan_clr ? head_reg : PTR_W'(head_reg + k_reg + ONE);

    always_comb
    begin
        case (ctl.vote_src)
            VSRC_LO:   vote_rd_addr = PTR_W'(head_reg + lo_reg);
            VSRC_HI:   vote_rd_addr = PTR_W'(head_reg + hi_reg);
            VSRC_HEAD: vote_rd_addr = head_reg;
            default:   vote_rd_addr = head_reg;
        endcase
    end

    always_comb
    begin
        vote_wr_en   = 1'b0;
        vote_wr_addr = tail_addr;
        vote_wr_data = '0;
        case (ctl.vote_upd)
            VUPD_DEC_LO:
            begin
                vote_wr_en   = 1'b1;
                vote_wr_addr = PTR_W'(head_reg + lo_reg);
                vote_wr_data = (vote_rd_reg == VOTE_MIN) ? VOTE_MIN
                                                         : VOTE_W'(vote_rd_reg - VOTE_W'(1));
            end
            VUPD_INC_HI:
            begin
                vote_wr_en   = 1'b1;
                vote_wr_addr = PTR_W'(head_reg + hi_reg);
                vote_wr_data = (vote_rd_reg == VOTE_MAX) ? VOTE_MAX
                                                         : VOTE_W'(vote_rd_reg + VOTE_W'(1));
            end
            default:
            begin
                if (ctl.push)
                begin
                    vote_wr_en = 1'b1;
                end
            end
        endcase
    end

    // first smallest and last largest over the window
    always_comb
    begin
        k_next   = k_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (ctl.scan_clr)
        begin
            k_next = '0;
        end
        else if (ctl.scan_step)
        begin
            k_next = PTR_W'(k_reg + ONE);
            if (k_reg == '0)
            begin
                lo_next  = '0;
                hi_next  = '0;
                min_next = smp_rd_reg;
                max_next = smp_rd_reg;
            end
            else
            begin
                if (smp_rd_reg < min_reg)
                begin
                    lo_next  = k_reg;
                    min_next = smp_rd_reg;
                end
                if (smp_rd_reg >= max_reg)
                begin
                    hi_next  = k_reg;
                    max_next = smp_rd_reg;
                end
            end
        end
    end

    always_comb
    begin
        head_next = head_reg;
        held_next = held_reg;
        if (emit_fire)
        begin
            head_next = PTR_W'(head_reg + ONE);
            held_next = PTR_W'(held_reg - ONE);
        end
        else if (ctl.push)
        begin
            held_next = PTR_W'(held_reg + ONE);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (vote_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            held_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            held_reg      <= held_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        min_reg <= min_next;
        max_reg <= max_next;
        if (in_fire)
        begin
            sample_reg <= sample_ch.sample;
            eos_reg    <= sample_ch.end_of_sequence;
        end
        if (emit_fire)
        begin
            out_vote_reg <= vote_rd_reg;
            out_last_reg <= (ctl.emit == EMIT_FLUSH) && (held_reg == ONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            smp_mem[tail_addr] <= sample_reg;
        end
        if (smp_rd_en)
        begin
            smp_rd_reg <= smp_mem[smp_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vote_wr_en)
        begin
            vote_mem[vote_wr_addr] <= vote_wr_data;
        end
        if (ctl.vote_src != VSRC_NONE)
        begin
            vote_rd_reg <= vote_mem[vote_rd_addr];
        end
    end

    assign vote_ch.valid     = out_valid_reg;
    assign vote_ch.vote      = out_vote_reg;
    assign vote_ch.last_vote = out_last_reg;

endmodule

@@ src/sliding_window_extrema_vote_core.sv @@
// top level of the sliding window extrema vote block
//
//   channel     dir  payload                    handshake
//   sample_ch   in   sample, end_of_sequence    valid / ready
//   vote_ch     out  vote, last_vote            valid / ready
//   apb         in   window_length at 0x0       psel / penable / pready
//
// a sample that fills the window is only stored; one that scores a window first runs
// a scan of the sample memory, one read per cycle over the effective window length w.
// a final sample then flushes each held vote with a read, an emit and a test step.
// reset clears the control state; the memories need no clearing pass.
// an output stall holds the sequencer at either emit step; a new sample is taken
// while the last vote still waits in the output register.
module sliding_window_extrema_vote_core import swev_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    swev_in_if.sink               sample_ch,
    swev_out_if.source            vote_ch
);

    logic [WLEN_W-1:0] window_length;
    ctl_word_t         ctl;
    status_t           status;

    swev_apb u_apb (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .window_length (window_length)
    );

    swev_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    swev_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .window_length (window_length),
        .status        (status),
        .sample_ch     (sample_ch),
        .vote_ch       (vote_ch)
    );

endmodule
